// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by ordered_list_insert_fetch for its concurrent checks.
// All checks sample on i_clk and are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define OLIF_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// When ante holds, cons holds in the same cycle.
`define OLIF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define OLIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/olif_pkg.sv =====
// ----------------------------------------------------------------------------
// olif_pkg
// Shared constants and types of the ordered list with positional insert.
// ----------------------------------------------------------------------------
package olif_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    // Fixed widths of the request and response fields.
    localparam int TYPE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Request kinds.
    localparam logic [TYPE_W-1:0] REQ_APPEND       = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_PREPEND      = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_INSERT_AFTER = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_FETCH        = 2'd3;

    // Status of the sequencer as seen by the top level.
    typedef struct packed {
        logic ready;   // idle, can take a request
        logic done;    // a result is held and waits to be moved out
        logic ok;      // success flag of the held result
    } t_seq_stat;

endpackage

// ===== sv/olif_if.sv =====
// ----------------------------------------------------------------------------
// olif_req_if / olif_rsp_if
// Valid/ready channels carrying list requests and list responses.
// ----------------------------------------------------------------------------
interface olif_req_if;
    logic                          valid;
    logic                          ready;
    logic [olif_pkg::TYPE_W-1:0]   req_type;
    logic [olif_pkg::VALUE_W-1:0]  value;
    logic [olif_pkg::INDEX_W-1:0]  index;

    modport source (output valid, output req_type, output value, output index,
                    input ready);
    modport sink   (input valid, input req_type, input value, input index,
                    output ready);
endinterface

interface olif_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [olif_pkg::VALUE_W-1:0]  read_value;
    logic [olif_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output ok, output read_value, output count,
                    input ready);
    modport sink   (input valid, input ok, input read_value, input count,
                    output ready);
endinterface

// ===== sv/olif_ram.sv =====
// ----------------------------------------------------------------------------
// olif_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module olif_ram #(
    parameter int WIDTH = olif_pkg::WORD_WIDTH_DEF,
    parameter int DEPTH = olif_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/olif_seq.sv =====
// ----------------------------------------------------------------------------
// olif_seq
// Request sequencer: holds the fill count, walks the move cursor down one
// entry per read and write to open a gap, and reads fetched RAM words.
// ----------------------------------------------------------------------------
module olif_seq #(
    parameter int DEPTH      = olif_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = olif_pkg::WORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [olif_pkg::TYPE_W-1:0]       i_req_type,
    input  logic [olif_pkg::VALUE_W-1:0]      i_value,
    input  logic [olif_pkg::INDEX_W-1:0]      i_index,
    input  logic                              i_take,
    output olif_pkg::t_seq_stat               o_stat,
    output logic [WORD_WIDTH-1:0]             o_rd_word,
    output logic [$clog2(DEPTH+1)-1:0]        o_fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > olif_pkg::INDEX_W) ? CW : olif_pkg::INDEX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOP  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_fill,  n_fill;
    logic [CW-1:0]         r_cur,   n_cur;
    logic [CW-1:0]         r_gap,   n_gap;
    logic [WORD_WIDTH-1:0] r_word,  n_word;
    logic [WORD_WIDTH-1:0] r_rd,    n_rd;
    logic                  r_ok,    n_ok;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    logic [63:0]           value_ext;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         fill_x;
    logic                  full;
    logic                  idx_ok;
    logic [CW-1:0]         cur_m1;

    assign value_ext = 64'(i_value);
    assign pos_x     = XW'(i_index);
    assign fill_x    = XW'(r_fill);
    assign full      = (r_fill == CW'(DEPTH));
    assign idx_ok    = (pos_x < fill_x);
    assign cur_m1    = r_cur - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cur     = r_cur;
        n_gap     = r_gap;
        n_word    = r_word;
        n_rd      = r_rd;
        n_ok      = r_ok;
        ram_we    = 1'b0;
        ram_waddr = r_cur[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = cur_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ok = 1'b0;
                    n_rd = '0;
                    if (i_req_type == olif_pkg::REQ_FETCH) begin
                        ram_raddr = pos_x[AW-1:0];
                        n_state   = idx_ok ? S_FETCH : S_DONE;
                    end else if (!full && (i_req_type != olif_pkg::REQ_INSERT_AFTER
                                           || idx_ok)) begin
                        n_cur   = r_fill;
                        n_word  = value_ext[WORD_WIDTH-1:0];
                        n_state = S_LOOP;
                        case (i_req_type)
                            olif_pkg::REQ_PREPEND:      n_gap = '0;
                            olif_pkg::REQ_INSERT_AFTER: n_gap = CW'(pos_x + XW'(1));
                            default:                    n_gap = r_fill;
                        endcase
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOOP: begin
                if (r_cur == r_gap) begin
                    // Gap is open: drop the new word in and count it.
                    ram_we    = 1'b1;
                    ram_waddr = r_gap[AW-1:0];
                    ram_wdata = r_word;
                    n_fill    = r_fill + CW'(1);
                    n_ok      = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                // Entry cur-1 was read last cycle; move it up one place.
                ram_we  = 1'b1;
                n_cur   = cur_m1;
                n_state = S_LOOP;
            end
            S_FETCH: begin
                n_rd    = ram_rdata;
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ok    <= n_ok;
        end
        r_cur  <= n_cur;
        r_gap  <= n_gap;
        r_word <= n_word;
        r_rd   <= n_rd;
    end

    olif_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.ready = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.ok    = r_ok;
    assign o_rd_word    = r_rd;
    assign o_fill       = r_fill;

endmodule

// ===== sv/ordered_list_insert_fetch.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_fetch
// Fixed-capacity ordered list of words with append, prepend, insert-after
// and fetch-by-index requests; one response per request.
// Requests arrive on i_req and responses leave on o_rsp, both valid/ready.
// An item is taken when valid and ready are high at a rising clock edge.
// The block handles one request at a time; i_req.ready is low while busy.
// A failed request goes straight to the done state. Append and fetch pass
// through the loop or the fetch state first, and an insert loops once per
// entry that it moves, so a prepend into a list of n entries loops n times.
// Each moved entry costs one RAM read and one RAM write on the single
// storage RAM. i_req.ready returns as the response loads, so a new item
// is taken only once the last one has left the sequencer.
// The response sits in an output register; a stalled receiver holds it
// there, and a finished next result waits in the sequencer until it frees.
// Synchronous reset empties the list (count zero); RAM contents are not
// cleared since only positions below the count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_insert_fetch #(
    parameter int DEPTH      = olif_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = olif_pkg::WORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olif_req_if.sink   i_req,
    olif_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    olif_pkg::t_seq_stat                w_stat;
    logic [WORD_WIDTH-1:0]              w_rd_word;
    logic [CW-1:0]                      w_fill;
    logic                               w_start;
    logic                               w_take;
    logic [63:0]                        w_rd_ext;
    logic [8:0]                         w_fill_ext;

    logic                               r_out_valid;
    logic                               r_out_ok;
    logic [olif_pkg::VALUE_W-1:0]       r_out_rd;
    logic [olif_pkg::COUNT_W-1:0]       r_out_count;

    // A request is taken only while the sequencer is idle.
    assign i_req.ready = w_stat.ready;
    assign w_start     = i_req.valid && w_stat.ready;

    // The output register can load when it is empty or being drained.
    assign w_take = !r_out_valid || o_rsp.ready;

    olif_seq #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req_type (i_req.req_type),
        .i_value    (i_req.value),
        .i_index    (i_req.index),
        .i_take     (w_take),
        .o_stat     (w_stat),
        .o_rd_word  (w_rd_word),
        .o_fill     (w_fill)
    );

    // The word and the count are fitted to the fixed response field widths.
    assign w_rd_ext   = 64'(w_rd_word);
    assign w_fill_ext = 9'(w_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_stat.done && w_take) begin
            r_out_ok    <= w_stat.ok;
            r_out_rd    <= w_rd_ext[olif_pkg::VALUE_W-1:0];
            r_out_count <= w_fill_ext[olif_pkg::COUNT_W-1:0];
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.count      = r_out_count;

    // The list never holds more than its capacity.
    `OLIF_ASSERT(a_fill_bound, w_fill <= CW'(DEPTH), "fill count above capacity")
    // Once a request is taken the block is busy in the next cycle.
    `OLIF_ASSERT_NEXT(a_busy_after_start, w_start, !i_req.ready, "ready after accept")
    // A failed request never returns data.
    `OLIF_ASSERT_IMPL(a_fail_zero, o_rsp.valid && !o_rsp.ok, o_rsp.read_value == '0,
        "failed response carries data")

endmodule

// ===== tb/sv/ordered_list_insert_fetch_test.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_fetch_test
// Self-checking bench for the ordered list with positional insert and fetch.
// A short table of directed requests covers the empty list, the range
// checks and the word extremes. Random requests then fill the list through
// a mix of appends, prepends and inserts, read it back between inserts, and
// keep fetching from and inserting into the full list. A local copy of the
// list predicts what the table leaves open. Both channels idle at random.
// ----------------------------------------------------------------------------
module ordered_list_insert_fetch_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = olif_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1150;
    // The slowest request is a prepend into fifteen entries. On top of that
    // come a long sender gap and a long receiver stall, each at most the
    // longest pick_gap gap, so IDLE_LIMIT idle cycles can only mean a hang.
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [olif_pkg::TYPE_W-1:0]  kind;
        logic [olif_pkg::VALUE_W-1:0] word;
        logic [olif_pkg::INDEX_W-1:0] pos;
    } list_req_t;

    typedef struct packed {
        logic                         ok;
        logic [olif_pkg::VALUE_W-1:0] read_value;
        logic [olif_pkg::COUNT_W-1:0] count;
    } list_rsp_t;

    // A directed row carries its response only where it is obvious from
    // the request alone; the other rows are left to the local list copy.
    typedef struct packed {
        list_req_t req;
        logic      known;
        list_rsp_t rsp;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 17;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Every position is out of range while the list is empty.
        '{'{olif_pkg::REQ_FETCH,        32'hFFFF_FFFF, 4'd0},  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{'{olif_pkg::REQ_INSERT_AFTER, 32'h1234_5678, 4'd0},  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd15}, 1'b1, '{1'b0, 32'h0, 5'd0}},
        // All-ones word at the end, then read straight back.
        '{'{olif_pkg::REQ_APPEND,       32'hFFFF_FFFF, 4'd15}, 1'b1, '{1'b1, 32'h0, 5'd1}},
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd0},  1'b1,
          '{1'b1, 32'hFFFF_FFFF, 5'd1}},
        // All-zero word in front moves the first entry up.
        '{'{olif_pkg::REQ_PREPEND,      32'h0,         4'd7},  1'b1, '{1'b1, 32'h0, 5'd2}},
        // Insert in the middle, then after the last entry (same as append).
        '{'{olif_pkg::REQ_INSERT_AFTER, 32'hA5A5_A5A5, 4'd0},  1'b0, '0},
        '{'{olif_pkg::REQ_INSERT_AFTER, 32'h5A5A_5A5A, 4'd2},  1'b0, '0},
        '{'{olif_pkg::REQ_FETCH,        32'hFFFF_FFFF, 4'd0},  1'b0, '0},
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd1},  1'b0, '0},
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd2},  1'b0, '0},
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd3},  1'b0, '0},
        // An index at or above the count is out of range for both kinds.
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd4},  1'b1, '{1'b0, 32'h0, 5'd4}},
        '{'{olif_pkg::REQ_INSERT_AFTER, 32'hDEAD_BEEF, 4'd15}, 1'b1, '{1'b0, 32'h0, 5'd4}},
        // Index must be ignored by append and prepend.
        '{'{olif_pkg::REQ_APPEND,       32'h1234_5678, 4'd15}, 1'b0, '0},
        '{'{olif_pkg::REQ_PREPEND,      32'h8000_0001, 4'd9},  1'b0, '0},
        '{'{olif_pkg::REQ_FETCH,        32'h0,         4'd5},  1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    olif_req_if req_ch ();
    olif_rsp_if rsp_ch ();

    ordered_list_insert_fetch u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    // Local copy of the list: words below list_fill are valid.
    logic [olif_pkg::VALUE_W-1:0] list_words [LIST_DEPTH];
    int                           list_fill = 0;

    // Responses still owed by the block, oldest first.
    list_rsp_t answers_due [$];
    int        mismatch_count = 0;

    // Applies one request to the local list and returns its response.
    function automatic list_rsp_t predict_list_answer(input list_req_t r);
        list_rsp_t a;
        int        slot;
        logic      full;
        a    = '0;
        full = (list_fill >= LIST_DEPTH);
        slot = -1;
        case (r.kind)
            olif_pkg::REQ_APPEND: begin
                if (!full) slot = list_fill;
            end
            olif_pkg::REQ_PREPEND: begin
                if (!full) slot = 0;
            end
            olif_pkg::REQ_INSERT_AFTER: begin
                if (!full && int'(r.pos) < list_fill) slot = int'(r.pos) + 1;
            end
            default: begin
                if (int'(r.pos) < list_fill) begin
                    a.ok         = 1'b1;
                    a.read_value = list_words[r.pos];
                end
            end
        endcase
        if (slot >= 0) begin
            // Open a gap at the slot by moving the later entries up one place.
            for (int n = list_fill; n > slot; n--) list_words[n] = list_words[n - 1];
            list_words[slot] = r.word;
            list_fill++;
            a.ok = 1'b1;
        end
        a.count = olif_pkg::COUNT_W'(list_fill);
        return a;
    endfunction

    // Mostly short gaps, now and then a long one; none at all when calm.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [olif_pkg::VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // While the list still has room, inserts of all three kinds are spread
    // among fetches so that moved entries get read back before the next
    // insert. Once it is full, inserts can only fail and fetches always hit.
    function automatic list_req_t pick_request();
        list_req_t r;
        int        roll;
        r.word = pick_word();
        r.pos  = olif_pkg::INDEX_W'($urandom_range(0, LIST_DEPTH - 1));
        roll   = $urandom_range(0, 99);
        if (list_fill < LIST_DEPTH) begin
            if (roll < 25) begin
                r.kind = ($urandom_range(0, 2) == 0) ? olif_pkg::REQ_APPEND :
                         ($urandom_range(0, 1) == 0) ? olif_pkg::REQ_PREPEND :
                                                       olif_pkg::REQ_INSERT_AFTER;
                if (r.kind == olif_pkg::REQ_INSERT_AFTER && list_fill > 0 &&
                    $urandom_range(0, 99) < 85) begin
                    r.pos = olif_pkg::INDEX_W'($urandom_range(0, list_fill - 1));
                end
            end else begin
                r.kind = olif_pkg::REQ_FETCH;
                if (list_fill > 0 && $urandom_range(0, 99) < 80) begin
                    r.pos = olif_pkg::INDEX_W'($urandom_range(0, list_fill - 1));
                end
            end
        end else begin
            if (roll < 30) begin
                r.kind = ($urandom_range(0, 2) == 0) ? olif_pkg::REQ_APPEND :
                         ($urandom_range(0, 1) == 0) ? olif_pkg::REQ_PREPEND :
                                                       olif_pkg::REQ_INSERT_AFTER;
            end else begin
                r.kind = olif_pkg::REQ_FETCH;
            end
        end
        return r;
    endfunction

    // Presents one request after the given gap and returns at the edge that
    // takes it. Valid stays high across back-to-back items, so it gets only
    // one assignment per edge.
    task automatic send_request(input list_req_t r, input int gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.value    <= r.word;
        req_ch.index    <= r.pos;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Request side: reset, directed table, random items, then drain.
    initial begin
        list_req_t r;
        list_rsp_t a;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= olif_pkg::REQ_APPEND;
        req_ch.value    <= '0;
        req_ch.index    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_request(DIRECTED[i].req, pick_gap(1'b0));
            a = predict_list_answer(DIRECTED[i].req);
            answers_due.push_back(DIRECTED[i].known ? DIRECTED[i].rsp : a);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = pick_request();
            // Every third stretch of 80 items runs without gaps.
            send_request(r, pick_gap((i / 80) % 3 == 1));
            answers_due.push_back(predict_list_answer(r));
        end
        req_ch.valid <= 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        // Give a stray extra response the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Response side: checks every item taken and stalls at random, but one
    // stretch in every four is calm and starts no new stall.
    initial begin
        list_rsp_t exp;
        int        stall_left;
        int        cyc;
        stall_left = 0;
        cyc        = 0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                if (answers_due.size() == 0) begin
                    $error("response with none expected: ok=%0b read_value=%h count=%0d",
                           rsp_ch.ok, rsp_ch.read_value, rsp_ch.count);
                    mismatch_count++;
                end else begin
                    exp = answers_due.pop_front();
                    if (rsp_ch.ok !== exp.ok) begin
                        $error("ok: expected %0b, actual %0b", exp.ok, rsp_ch.ok);
                        mismatch_count++;
                    end
                    if (rsp_ch.read_value !== exp.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               exp.read_value, rsp_ch.read_value);
                        mismatch_count++;
                    end
                    if (rsp_ch.count !== exp.count) begin
                        $error("count: expected %0d, actual %0d", exp.count, rsp_ch.count);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ((cyc / 300) % 4 != 3 && $urandom_range(0, 99) < 30) begin
                    stall_left = pick_gap(1'b0);
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $error("no item moved on either channel for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
